FILE: sv/gdcr_pkg.sv
// ----------------------------------------------------------------------------
// gdcr_pkg
// Shared types, widths and defaults of the grid DDA column raycaster.
// ----------------------------------------------------------------------------
package gdcr_pkg;

  localparam int MAP_SIZE_DEF      = 8;
  localparam int SCREEN_WIDTH_DEF  = 640;
  localparam int SCREEN_HEIGHT_DEF = 480;
  localparam int TEX_SIZE_DEF      = 16;

  localparam int POS_W   = 19;
  localparam int VEC_W   = 18;
  localparam int CFG_W   = 19;
  localparam int CFG_IW  = 3;
  localparam int ROW_W   = 3;
  localparam int VAL_W   = 8;
  localparam int COL_W   = 10;
  localparam int LH_W    = 16;
  localparam int ROWS_W  = 9;
  localparam int TEXC_W  = 4;

  localparam logic [POS_W-1:0] POS_X_RST   = 19'd262144;
  localparam logic [POS_W-1:0] POS_Y_RST   = 19'd262144;
  localparam logic [VEC_W-1:0] DIR_X_RST   = 18'h30000;
  localparam logic [VEC_W-1:0] DIR_Y_RST   = 18'd0;
  localparam logic [VEC_W-1:0] PLANE_X_RST = 18'd0;
  localparam logic [VEC_W-1:0] PLANE_Y_RST = 18'd43254;

  typedef enum logic [CFG_IW-1:0] {
    REG_POS_X   = 3'd0,
    REG_POS_Y   = 3'd1,
    REG_DIR_X   = 3'd2,
    REG_DIR_Y   = 3'd3,
    REG_PLANE_X = 3'd4,
    REG_PLANE_Y = 3'd5
  } cfg_reg_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

endpackage

FILE: sv/gdcr_ram.sv
// ----------------------------------------------------------------------------
// gdcr_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gdcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/gdcr_div.sv
// ----------------------------------------------------------------------------
// gdcr_div
// Restoring unsigned divider, one quotient bit per cycle, done strobe.
// ----------------------------------------------------------------------------
module gdcr_div #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quot
);

  localparam int CTW = $clog2(W + 1);

  logic [W-1:0]   rem_r;
  logic [W-1:0]   q_r;
  logic [W-1:0]   den_r;
  logic [CTW-1:0] cnt_r;
  logic           run_r;
  logic           done_r;
  logic [W:0]     sh;
  logic [W:0]     diff;
  logic           ge;

  always_comb begin
    sh   = {rem_r, q_r[W-1]};
    ge   = sh >= {1'b0, den_r};
    diff = sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CTW'(W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= ge ? diff[W-1:0] : sh[W-1:0];
      q_r   <= {q_r[W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: sv/grid_dda_column_raycaster_top.sv
// ----------------------------------------------------------------------------
// grid_dda_column_raycaster_top
// Column raycaster over a grid map held in a synchronous RAM.
// ----------------------------------------------------------------------------
// After reset the block clears every map cell with busy high. A cell write
// item is taken in idle and leaves busy low. A cast item derives the camera
// offset by a reciprocal multiplication, then runs the two reciprocals and
// the height division on one shared bit-serial divider, with a map read for
// each grid step in between. A ray that leaves the map skips the height
// division, and a camera outside the map skips the divider. Each result
// shows on out_* for a single cycle under out_valid and cannot be held off.
// ----------------------------------------------------------------------------
module grid_dda_column_raycaster_top #(
  parameter int MAP_SIZE      = gdcr_pkg::MAP_SIZE_DEF,
  parameter int SCREEN_WIDTH  = gdcr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = gdcr_pkg::SCREEN_HEIGHT_DEF,
  parameter int TEX_SIZE      = gdcr_pkg::TEX_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [gdcr_pkg::ROW_W-1:0]    in_cell_row,
  input  logic [gdcr_pkg::ROW_W-1:0]    in_cell_col,
  input  logic [gdcr_pkg::VAL_W-1:0]    in_cell_value,
  input  logic [gdcr_pkg::COL_W-1:0]    in_column,
  output logic                          out_valid,
  output logic [gdcr_pkg::COL_W-1:0]    out_column_out,
  output logic                          out_status,
  output logic                          out_side_hit,
  output logic [gdcr_pkg::LH_W-1:0]     out_line_height,
  output logic [gdcr_pkg::ROWS_W-1:0]   out_draw_start,
  output logic [gdcr_pkg::ROWS_W-1:0]   out_draw_end,
  output logic [gdcr_pkg::VAL_W-1:0]    out_texture_index,
  output logic [gdcr_pkg::TEXC_W-1:0]   out_tex_column,
  input  logic                          cfg_we,
  input  logic [gdcr_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [gdcr_pkg::CFG_W-1:0]    cfg_data
);

  import gdcr_pkg::*;

  localparam int CELLS = MAP_SIZE * MAP_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(MAP_SIZE + 1);
  localparam int CW    = ((IW > 3) ? IW : 3) + 2;
  localparam int NSTEP = 2 * MAP_SIZE + 2;
  localparam int NW    = $clog2(NSTEP + 1);
  localparam int SDW   = 33 + NW + 1;
  localparam int DW    = SDW;
  localparam int XW    = $clog2(SCREEN_WIDTH);
  localparam int RXW   = 20;
  localparam int HALF  = SCREEN_HEIGHT / 2;
  localparam logic signed [CW-1:0] MAP_S = CW'(MAP_SIZE);
  localparam logic [32:0] DELTA_SAT = 33'h1_0000_0000;

  // column * 2^17 / SCREEN_WIDTH as a multiply by a rounded-up reciprocal
  localparam int     CAM_SH    = 2 * XW;
  localparam int     CAM_MW    = XW + 19;
  localparam int     CAM_PW    = CAM_MW + XW;
  localparam longint CAM_RECIP = ((longint'(1) << (CAM_SH + 17)) +
                                  longint'(SCREEN_WIDTH) - 1) / longint'(SCREEN_WIDTH);
  localparam logic [CAM_MW-1:0] CAM_M = CAM_MW'(CAM_RECIP);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CAM, S_MUL, S_RAY, S_DIVX, S_DIVY, S_SIDE,
    S_STEP, S_CHECK, S_PERP, S_LH, S_WALL, S_DONE
  } state_t;

  state_t state_r;

  logic [POS_W-1:0] pos_x_r, pos_y_r;
  logic [VEC_W-1:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;

  logic [AW-1:0]          clr_cnt_r;
  logic [COL_W-1:0]       column_r;
  logic [XW-1:0]          cidx_r;
  logic signed [17:0]     cam_r;
  logic signed [35:0]     prx_r, pry_r;
  logic signed [RXW-1:0]  rx_r, ry_r;
  logic signed [CW-1:0]   mx_r, my_r;
  logic [32:0]            ddx_r, ddy_r;
  logic [SDW-1:0]         sdx_r, sdy_r, perp_r;
  logic                   side_r;
  logic                   miss_r;
  logic [NW-1:0]          n_r;
  logic [VAL_W-1:0]       cell_r;
  logic [LH_W-1:0]        lh_r;
  logic [31:0]            wprod_r;
  logic                   div_go_r;

  logic                   out_valid_r;
  logic [COL_W-1:0]       out_column_r;
  logic                   out_status_r, out_side_r;
  logic [LH_W-1:0]        out_lh_r;
  logic [ROWS_W-1:0]      out_ds_r, out_de_r;
  logic [VAL_W-1:0]       out_tidx_r;
  logic [TEXC_W-1:0]      out_tex_r;

  // map store
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;
  logic              wr_ok;

  // divider
  logic [DW-1:0] div_num, div_den, div_q;
  logic          div_done;

  // dda step
  logic                 xstep;
  logic signed [CW-1:0] nmx, nmy;
  logic                 nout;
  logic [DW-1:0]        rx_abs, ry_abs;
  logic [16:0]          fx, fy;
  logic signed [RXW-1:0] rx_nxt, ry_nxt;
  logic [15:0]          frac;
  logic [31:0]          tex_prod;
  logic [8:0]           texv;
  logic                 flip;
  logic signed [17:0]   ds_s, de_s;
  logic [CAM_PW-1:0]    cam_prod;

  gdcr_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gdcr_div #(.W(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    wr_ok = (32'(in_cell_row) < 32'(MAP_SIZE)) && (32'(in_cell_col) < 32'(MAP_SIZE));
    ram_we    = (state_r == S_CLEAR) ||
                ((state_r == S_IDLE) && start && (in_op == OP_WRITE) && wr_ok);
    ram_waddr = (state_r == S_CLEAR) ? clr_cnt_r :
                AW'(32'(in_cell_row) * 32'(MAP_SIZE) + 32'(in_cell_col));
    ram_wdata = (state_r == S_CLEAR) ? '0 : in_cell_value;

    xstep = sdx_r < sdy_r;
    nmx   = (xstep) ? (rx_r[RXW-1] ? mx_r - 1'b1 : mx_r + 1'b1) : mx_r;
    nmy   = (!xstep) ? (ry_r[RXW-1] ? my_r - 1'b1 : my_r + 1'b1) : my_r;
    nout  = nmx[CW-1] || nmy[CW-1] || (nmx >= MAP_S) || (nmy >= MAP_S);
    ram_raddr = AW'(32'(unsigned'(nmx)) * 32'(MAP_SIZE) + 32'(unsigned'(nmy)));

    rx_abs = rx_r[RXW-1] ? DW'(unsigned'(-rx_r)) : DW'(unsigned'(rx_r));
    ry_abs = ry_r[RXW-1] ? DW'(unsigned'(-ry_r)) : DW'(unsigned'(ry_r));
    fx = rx_r[RXW-1] ? {1'b0, pos_x_r[15:0]} : 17'h10000 - {1'b0, pos_x_r[15:0]};
    fy = ry_r[RXW-1] ? {1'b0, pos_y_r[15:0]} : 17'h10000 - {1'b0, pos_y_r[15:0]};

    cam_prod = CAM_PW'(cidx_r) * CAM_PW'(CAM_M);

    rx_nxt = RXW'($signed(dir_x_r)) + RXW'(prx_r >>> 16);
    ry_nxt = RXW'($signed(dir_y_r)) + RXW'(pry_r >>> 16);

    unique case (state_r)
      S_DIVX:  begin
        div_num = DW'(DELTA_SAT);
        div_den = rx_abs;
      end
      S_DIVY:  begin
        div_num = DW'(DELTA_SAT);
        div_den = ry_abs;
      end
      default: begin
        div_num = DW'(SCREEN_HEIGHT) << 16;
        div_den = perp_r;
      end
    endcase

    frac     = (side_r ? pos_x_r[15:0] : pos_y_r[15:0]) + wprod_r[31:16];
    tex_prod = 32'(frac) * 32'(TEX_SIZE);
    flip     = (!side_r && !rx_r[RXW-1] && (rx_r != '0)) || (side_r && ry_r[RXW-1]);
    texv     = flip ? 9'(TEX_SIZE - 1) - 9'(tex_prod >> 16) : 9'(tex_prod >> 16);
    ds_s     = 18'(HALF) - {3'b0, lh_r[15:1]};
    de_s     = 18'(HALF) + {3'b0, lh_r[15:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pos_x_r     <= POS_X_RST;
      pos_y_r     <= POS_Y_RST;
      dir_x_r     <= DIR_X_RST;
      dir_y_r     <= DIR_Y_RST;
      plane_x_r   <= PLANE_X_RST;
      plane_y_r   <= PLANE_Y_RST;
    end else begin
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_POS_X:   pos_x_r   <= cfg_data;
          REG_POS_Y:   pos_y_r   <= cfg_data;
          REG_DIR_X:   dir_x_r   <= cfg_data[VEC_W-1:0];
          REG_DIR_Y:   dir_y_r   <= cfg_data[VEC_W-1:0];
          REG_PLANE_X: plane_x_r <= cfg_data[VEC_W-1:0];
          REG_PLANE_Y: plane_y_r <= cfg_data[VEC_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == AW'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start && (in_op == OP_CAST)) begin
            column_r <= in_column;
            cidx_r   <= (32'(in_column) < 32'(SCREEN_WIDTH)) ? XW'(in_column) :
                        XW'(SCREEN_WIDTH - 1);
            miss_r   <= 1'b0;
            state_r  <= S_CAM;
          end
        end
        S_CAM: begin
          cam_r   <= $signed(cam_prod[CAM_SH+17:CAM_SH] - 18'd65536);
          state_r <= S_MUL;
        end
        S_MUL: begin
          prx_r   <= $signed(plane_x_r) * cam_r;
          pry_r   <= $signed(plane_y_r) * cam_r;
          state_r <= S_RAY;
        end
        S_RAY: begin
          rx_r <= rx_nxt;
          ry_r <= ry_nxt;
          mx_r <= CW'(pos_x_r[18:16]);
          my_r <= CW'(pos_y_r[18:16]);
          n_r  <= '0;
          if ((32'(pos_x_r[18:16]) >= 32'(MAP_SIZE)) ||
              (32'(pos_y_r[18:16]) >= 32'(MAP_SIZE))) begin
            miss_r  <= 1'b1;
            state_r <= S_DONE;
          end else begin
            div_go_r <= 1'b1;
            state_r  <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            ddx_r    <= (rx_r == '0) ? DELTA_SAT : div_q[32:0];
            div_go_r <= 1'b1;
            state_r  <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            ddy_r   <= (ry_r == '0) ? DELTA_SAT : div_q[32:0];
            state_r <= S_SIDE;
          end
        end
        S_SIDE: begin
          sdx_r   <= SDW'((50'(fx) * 50'(ddx_r)) >> 16);
          sdy_r   <= SDW'((50'(fy) * 50'(ddy_r)) >> 16);
          state_r <= S_STEP;
        end
        S_STEP: begin
          if (n_r == NW'(NSTEP)) begin
            miss_r  <= 1'b1;
            state_r <= S_DONE;
          end else begin
            n_r <= n_r + 1'b1;
            mx_r <= nmx;
            my_r <= nmy;
            side_r <= !xstep;
            if (xstep) begin
              sdx_r <= sdx_r + SDW'(ddx_r);
            end else begin
              sdy_r <= sdy_r + SDW'(ddy_r);
            end
            if (nout) begin
              miss_r  <= 1'b1;
              state_r <= S_DONE;
            end else begin
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (ram_rdata != '0) begin
            cell_r  <= ram_rdata;
            state_r <= S_PERP;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_PERP: begin
          perp_r   <= side_r ? sdy_r - SDW'(ddy_r) : sdx_r - SDW'(ddx_r);
          div_go_r <= 1'b1;
          state_r  <= S_LH;
        end
        S_LH: begin
          if (div_done) begin
            lh_r    <= (div_q >= DW'(65536)) ? 16'hFFFF : div_q[15:0];
            state_r <= S_WALL;
          end
        end
        S_WALL: begin
          wprod_r <= 32'($signed({1'b0, perp_r[31:0]}) *
                         (side_r ? 33'(rx_r) : 33'(ry_r)));
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid_r  <= 1'b1;
          out_column_r <= column_r;
          out_status_r <= miss_r;
          if (miss_r) begin
            out_side_r <= 1'b0;
            out_lh_r   <= '0;
            out_ds_r   <= '0;
            out_de_r   <= '0;
            out_tidx_r <= '0;
            out_tex_r  <= '0;
          end else begin
            out_side_r <= side_r;
            out_lh_r   <= lh_r;
            out_ds_r   <= ds_s[17] ? '0 : ds_s[ROWS_W-1:0];
            out_de_r   <= (de_s >= 18'(SCREEN_HEIGHT)) ? ROWS_W'(SCREEN_HEIGHT - 1) :
                          de_s[ROWS_W-1:0];
            out_tidx_r <= cell_r - 1'b1;
            out_tex_r  <= texv[TEXC_W-1:0];
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_column_out    = out_column_r;
  assign out_status        = out_status_r;
  assign out_side_hit      = out_side_r;
  assign out_line_height   = out_lh_r;
  assign out_draw_start    = out_ds_r;
  assign out_draw_end      = out_de_r;
  assign out_texture_index = out_tidx_r;
  assign out_tex_column    = out_tex_r;

endmodule

FILE: sv/gdcr_checker.sv
// ----------------------------------------------------------------------------
// gdcr_checker
// Port level checks of the raycaster, bound to the top level.
// ----------------------------------------------------------------------------
module gdcr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_op,
  input logic                        out_valid,
  input logic                        out_status,
  input logic                        out_side_hit,
  input logic [gdcr_pkg::LH_W-1:0]   out_line_height,
  input logic [gdcr_pkg::ROWS_W-1:0] out_draw_start,
  input logic [gdcr_pkg::ROWS_W-1:0] out_draw_end,
  input logic [gdcr_pkg::TEXC_W-1:0] out_tex_column
);

  import gdcr_pkg::*;

  // map clearing keeps the block busy right after reset
  a_clear_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_op == OP_CAST) |=> busy)
    else $error("cast item did not make the block busy");

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_side_hit && (out_line_height == '0) &&
                                (out_tex_column == '0))
    else $error("miss result carries hit data");

  a_rows_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status |-> out_draw_start <= out_draw_end)
    else $error("draw start after draw end");

endmodule

bind grid_dda_column_raycaster_top gdcr_checker u_gdcr_checker (.*);
